// ===== rtl/stia_pkg.sv =====
// ----------------------------------------------------------------------------
// stia_pkg
// Shared types and codes for the stick-to-position integrator.
// ----------------------------------------------------------------------------
package stia_pkg;

  localparam int unsigned PosW  = 8;
  localparam int unsigned StepW = 4;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 2;

  localparam logic [PosW-1:0] PosReset = 8'd127;
  localparam logic [7:0]      Center   = 8'h80;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_VARIANT       = 2'd0,
    REG_SENSITIVITY   = 2'd1,
    REG_PLAYER_SELECT = 2'd2
  } reg_index_t;

  // operating modes
  typedef enum logic {
    MODE_TRACKBALL = 1'b0,
    MODE_PADDLE    = 1'b1
  } mode_t;

  // sensitivity code that selects no table
  localparam logic [1:0] SensNone = 2'd3;

  typedef struct packed {
    mode_t      variant;
    logic [1:0] sensitivity;
    logic       player_select;
  } cfg_t;

  typedef struct packed {
    logic                    hit;
    logic signed [StepW-1:0] step;
  } zone_t;

endpackage

// ===== rtl/stia_zone.sv =====
// ----------------------------------------------------------------------------
// stia_zone
// Dead-zone threshold lookup: maps one stick reading to a signed step
// through one of four threshold tables.
// ----------------------------------------------------------------------------
module stia_zone (
  input  logic [1:0]     tbl,
  input  logic [7:0]     reading,
  output stia_pkg::zone_t result
);
  import stia_pkg::*;

  logic high_side;

  assign high_side = (reading > Center);

  // thresholds are tried strongest first, first match wins
  always_comb begin
    result = '{hit: 1'b0, step: '0};
    case (tbl)
      2'd0: begin
        if (high_side) begin
          if      (reading >= 8'he0) result = '{1'b1, 4'sd2};
          else if (reading >= 8'ha0) result = '{1'b1, 4'sd1};
        end else begin
          if      (reading <= 8'h1f) result = '{1'b1, -4'sd3};
          else if (reading <= 8'h5f) result = '{1'b1, -4'sd1};
        end
      end
      2'd1: begin
        if (high_side) begin
          if      (reading >= 8'hf0) result = '{1'b1, 4'sd3};
          else if (reading >= 8'hd0) result = '{1'b1, 4'sd2};
          else if (reading >= 8'ha0) result = '{1'b1, 4'sd1};
        end else begin
          if      (reading <= 8'h0f) result = '{1'b1, -4'sd3};
          else if (reading <= 8'h2f) result = '{1'b1, -4'sd2};
          else if (reading <= 8'h5f) result = '{1'b1, -4'sd1};
        end
      end
      2'd2: begin
        if (high_side) begin
          if      (reading >= 8'hf8) result = '{1'b1, 4'sd4};
          else if (reading >= 8'he8) result = '{1'b1, 4'sd3};
          else if (reading >= 8'hd0) result = '{1'b1, 4'sd2};
          else if (reading >= 8'h98) result = '{1'b1, 4'sd1};
        end else begin
          if      (reading <= 8'h07) result = '{1'b1, -4'sd4};
          else if (reading <= 8'h17) result = '{1'b1, -4'sd3};
          else if (reading <= 8'h2f) result = '{1'b1, -4'sd2};
          else if (reading <= 8'h67) result = '{1'b1, -4'sd1};
        end
      end
      default: begin
        if (high_side) begin
          if      (reading >= 8'hf8) result = '{1'b1, 4'sd5};
          else if (reading >= 8'he8) result = '{1'b1, 4'sd4};
          else if (reading >= 8'hd8) result = '{1'b1, 4'sd3};
          else if (reading >= 8'hc0) result = '{1'b1, 4'sd2};
          else if (reading >= 8'h98) result = '{1'b1, 4'sd1};
        end else begin
          if      (reading <= 8'h07) result = '{1'b1, -4'sd5};
          else if (reading <= 8'h17) result = '{1'b1, -4'sd4};
          else if (reading <= 8'h27) result = '{1'b1, -4'sd3};
          else if (reading <= 8'h3f) result = '{1'b1, -4'sd2};
          else if (reading <= 8'h67) result = '{1'b1, -4'sd1};
        end
      end
    endcase
  end

endmodule

// ===== rtl/stia_update.sv =====
// ----------------------------------------------------------------------------
// stia_update
// Next-position logic: direction steps, table steps, wrapping update in
// trackball mode and clamped update of one player in paddle mode.
// ----------------------------------------------------------------------------
module stia_update (
  input  stia_pkg::cfg_t               cfg,
  input  logic [stia_pkg::PosW-1:0]    pos_a,
  input  logic [stia_pkg::PosW-1:0]    pos_b,
  input  logic [7:0]                   stick_x,
  input  logic [7:0]                   stick_y,
  input  logic [3:0]                   directions,
  output logic [stia_pkg::PosW-1:0]    pos_a_next,
  output logic [stia_pkg::PosW-1:0]    pos_b_next
);
  import stia_pkg::*;

  logic [1:0]              tbl_x;
  zone_t                   zone_x;
  zone_t                   zone_y;
  logic                    table_on;
  logic signed [StepW-1:0] step_x;
  logic signed [StepW-1:0] step_y;
  logic signed [StepW-1:0] paddle_step;
  logic [PosW-1:0]         paddle_pos;
  logic signed [PosW+1:0]  paddle_sum;
  logic [PosW-1:0]         paddle_clamped;

  // paddle mode uses the next table up
  assign tbl_x    = (cfg.variant == MODE_PADDLE) ? cfg.sensitivity + 2'd1 : cfg.sensitivity;
  assign table_on = (cfg.sensitivity != SensNone);

  stia_zone u_zone_x (
    .tbl     (tbl_x),
    .reading (stick_x),
    .result  (zone_x)
  );

  stia_zone u_zone_y (
    .tbl     (cfg.sensitivity),
    .reading (stick_y),
    .result  (zone_y)
  );

  // right beats left, down beats up
  always_comb begin
    if (directions[3])      step_x = 4'sd1;
    else if (directions[2]) step_x = -4'sd1;
    else                    step_x = 4'sd0;
    if (table_on && zone_x.hit) step_x = zone_x.step;

    if (directions[1])      step_y = 4'sd1;
    else if (directions[0]) step_y = -4'sd1;
    else                    step_y = 4'sd0;
    if (table_on && zone_y.hit) step_y = zone_y.step;
  end

  assign paddle_step = (table_on && zone_x.hit) ? zone_x.step : 4'sd0;
  assign paddle_pos  = cfg.player_select ? pos_b : pos_a;
  assign paddle_sum  = $signed({2'b00, paddle_pos})
                     + {{(PosW+2-StepW){paddle_step[StepW-1]}}, paddle_step};

  always_comb begin
    if (paddle_sum < 0)                          paddle_clamped = '0;
    else if (paddle_sum > $signed(10'sd255))     paddle_clamped = '1;
    else                                         paddle_clamped = paddle_sum[PosW-1:0];
  end

  always_comb begin
    if (cfg.variant == MODE_TRACKBALL) begin
      // negated step, wrapping
      pos_a_next = pos_a - {{(PosW-StepW){step_x[StepW-1]}}, step_x};
      pos_b_next = pos_b - {{(PosW-StepW){step_y[StepW-1]}}, step_y};
    end else begin
      pos_a_next = cfg.player_select ? pos_a : paddle_clamped;
      pos_b_next = cfg.player_select ? paddle_clamped : pos_b;
    end
  end

endmodule

// ===== rtl/stick_to_position_integrator_core.sv =====
// ----------------------------------------------------------------------------
// stick_to_position_integrator_core
// Frame-rate stick integrator: turns stick readings and direction flags into
// two accumulated 8-bit positions.
// ----------------------------------------------------------------------------
// One frame enters as a beat on the slave side, and one beat with both
// positions after the update leaves on the master side. A frame is first
// captured in an input register. The whole update then runs as combinational
// logic into the position and output registers. The block takes a new frame
// every cycle while the master side is ready. A frame moves on from the input
// register once the output register is free, and its beat is shown on the
// master side from the output register. While a result waits for the master
// side, the input register can take one more frame, and then the slave side
// stalls. Configuration writes are always taken and should only be issued
// while no frame is in flight. Positions start at 127 after reset.
module stick_to_position_integrator_core (
  input  logic                           clk,
  input  logic                           rst,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stia_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [stia_pkg::CfgDataW-1:0]  cfg_data,
  // frame input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,  // stick_x[7:0], stick_y[15:8],
                                                   // directions[19:16], zero pad
  // positions output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata   // position_a[7:0], position_b[15:8]
);
  import stia_pkg::*;

  cfg_t            cfg;
  logic            in_valid;
  logic [7:0]      in_stick_x;
  logic [7:0]      in_stick_y;
  logic [3:0]      in_directions;
  logic [PosW-1:0] pos_a;
  logic [PosW-1:0] pos_b;
  logic [PosW-1:0] pos_a_next;
  logic [PosW-1:0] pos_b_next;
  logic            out_valid;
  logic [PosW-1:0] out_a;
  logic [PosW-1:0] out_b;
  logic            out_free;
  logic            advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{variant: MODE_TRACKBALL, sensitivity: 2'd0, player_select: 1'b0};
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_VARIANT:       cfg.variant       <= mode_t'(cfg_data[0]);
        REG_SENSITIVITY:   cfg.sensitivity   <= cfg_data[1:0];
        REG_PLAYER_SELECT: cfg.player_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_stick_x    <= s_tdata[7:0];
      in_stick_y    <= s_tdata[15:8];
      in_directions <= s_tdata[19:16];
    end
  end

  stia_update u_update (
    .cfg        (cfg),
    .pos_a      (pos_a),
    .pos_b      (pos_b),
    .stick_x    (in_stick_x),
    .stick_y    (in_stick_y),
    .directions (in_directions),
    .pos_a_next (pos_a_next),
    .pos_b_next (pos_b_next)
  );

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_a <= PosReset;
      pos_b <= PosReset;
    end else if (advance) begin
      pos_a <= pos_a_next;
      pos_b <= pos_b_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_a <= pos_a_next;
      out_b <= pos_b_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_b, out_a};

`ifndef NO_ASSERTIONS
  // a shown result always matches the position state
  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_a == pos_a && out_b == pos_b))
    else $error("output beat differs from position state");

  // paddle mode leaves the other player alone
  a_paddle_a_untouched: assert property (@(posedge clk) disable iff (rst)
    (advance && cfg.variant == MODE_PADDLE && cfg.player_select) |=> $stable(pos_a))
    else $error("paddle update changed player one");

  a_paddle_b_untouched: assert property (@(posedge clk) disable iff (rst)
    (advance && cfg.variant == MODE_PADDLE && !cfg.player_select) |=> $stable(pos_b))
    else $error("paddle update changed player two");

  // a held frame is never dropped while the output is blocked
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> (in_valid && $stable(in_stick_x) && $stable(in_stick_y)))
    else $error("pending frame lost under backpressure");

  // positions only move when a frame is processed
  a_pos_quiet: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(pos_a) && $stable(pos_b)))
    else $error("positions changed without a frame");
`endif

endmodule

// ===== test/stick_position_checker.sv =====
// ----------------------------------------------------------------------------
// stick_position_checker
// Watches the config, frame and position channels of the stick integrator,
// keeps its own copy of the positions and settings, predicts the position
// beat for every accepted frame and compares it field by field.
// ----------------------------------------------------------------------------
module stick_position_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [stia_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [stia_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // stick_x[7:0], stick_y[15:8],
                                                    // directions[19:16]
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [15:0]                    m_tdata,   // position_a[7:0], position_b[15:8]
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import stia_pkg::*;

  mode_t          mode;
  logic [1:0]     sens;
  logic           psel;
  logic [PosW-1:0] pos_a;
  logic [PosW-1:0] pos_b;
  logic [15:0]    expected_positions[$];

  // step for one reading from dead-zone table tbl, zero when no threshold is passed
  function automatic int zone_step(int tbl, logic [7:0] r);
    if (r > Center) begin
      case (tbl)
        0: begin
          if (r >= 8'he0) return 2;
          if (r >= 8'ha0) return 1;
        end
        1: begin
          if (r >= 8'hf0) return 3;
          if (r >= 8'hd0) return 2;
          if (r >= 8'ha0) return 1;
        end
        2: begin
          if (r >= 8'hf8) return 4;
          if (r >= 8'he8) return 3;
          if (r >= 8'hd0) return 2;
          if (r >= 8'h98) return 1;
        end
        default: begin
          if (r >= 8'hf8) return 5;
          if (r >= 8'he8) return 4;
          if (r >= 8'hd8) return 3;
          if (r >= 8'hc0) return 2;
          if (r >= 8'h98) return 1;
        end
      endcase
    end else begin
      case (tbl)
        0: begin
          if (r <= 8'h1f) return -3;
          if (r <= 8'h5f) return -1;
        end
        1: begin
          if (r <= 8'h0f) return -3;
          if (r <= 8'h2f) return -2;
          if (r <= 8'h5f) return -1;
        end
        2: begin
          if (r <= 8'h07) return -4;
          if (r <= 8'h17) return -3;
          if (r <= 8'h2f) return -2;
          if (r <= 8'h67) return -1;
        end
        default: begin
          if (r <= 8'h07) return -5;
          if (r <= 8'h17) return -4;
          if (r <= 8'h27) return -3;
          if (r <= 8'h3f) return -2;
          if (r <= 8'h67) return -1;
        end
      endcase
    end
    return 0;
  endfunction

  task automatic integrate_frame(logic [23:0] frame);
    logic [7:0] sx;
    logic [7:0] sy;
    logic [3:0] dir;
    int         step_x;
    int         step_y;
    int         t;
    int         sum;
    sx  = frame[7:0];
    sy  = frame[15:8];
    dir = frame[19:16];
    if (mode == MODE_TRACKBALL) begin
      // down beats up, right beats left
      step_x = 0;
      if (dir[2]) step_x = -1;
      if (dir[3]) step_x = 1;
      step_y = 0;
      if (dir[0]) step_y = -1;
      if (dir[1]) step_y = 1;
      if (sens != SensNone) begin
        t = zone_step(int'(sens), sx);
        if (t != 0) step_x = t;
        t = zone_step(int'(sens), sy);
        if (t != 0) step_y = t;
      end
      pos_a = pos_a - step_x[7:0];
      pos_b = pos_b - step_y[7:0];
    end else begin
      step_x = (sens != SensNone) ? zone_step(int'(sens) + 1, sx) : 0;
      sum = (psel ? int'(pos_b) : int'(pos_a)) + step_x;
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      if (psel) pos_b = sum[7:0];
      else pos_a = sum[7:0];
    end
    expected_positions.push_back({pos_b, pos_a});
  endtask

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      mode  = MODE_TRACKBALL;
      sens  = 2'd0;
      psel  = 1'b0;
      pos_a = PosReset;
      pos_b = PosReset;
      expected_positions.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VARIANT:       mode = mode_t'(cfg_data[0]);
          REG_SENSITIVITY:   sens = cfg_data;
          REG_PLAYER_SELECT: psel = cfg_data[0];
          default: ;
        endcase
      end
      // a result leaves only after its frame has passed the input and output registers, so check before predicting
      if (m_tvalid && m_tready) begin
        if (expected_positions.size() == 0) begin
          $display("%0t ns: position beat with none expected, got a=%0d b=%0d",
                   $time, m_tdata[7:0], m_tdata[15:8]);
          mismatches++;
        end else begin
          want = expected_positions.pop_front();
          if (m_tdata[7:0] !== want[7:0]) begin
            $display("%0t ns: position_a expected %0d, got %0d",
                     $time, want[7:0], m_tdata[7:0]);
            mismatches++;
          end
          if (m_tdata[15:8] !== want[15:8]) begin
            $display("%0t ns: position_b expected %0d, got %0d",
                     $time, want[15:8], m_tdata[15:8]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) integrate_frame(s_tdata);
      outstanding <= expected_positions.size();
    end
  end

endmodule

// ===== test/stick_to_position_integrator_core_tb.sv =====
// ----------------------------------------------------------------------------
// stick_to_position_integrator_core_tb
// Drives frames and config writes into the stick integrator with bursty
// input and a stalling output side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module stick_to_position_integrator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;
  localparam int FrameTarget = 1950;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [1:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic [23:0] s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_ready;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;
  int          mismatches;
  int          outstanding;
  int          idle_cycles   = 0;
  int          frames_sent   = 0;
  int          config_phases = 0;

  // dead-zone edges and center, probed from both sides
  logic [7:0] zone_marks [0:18] = '{8'h80, 8'he0, 8'ha0, 8'h1f, 8'h5f, 8'hf0, 8'hd0,
                                    8'h0f, 8'h2f, 8'hf8, 8'he8, 8'h98, 8'h07, 8'h17,
                                    8'h67, 8'hd8, 8'hc0, 8'h27, 8'h3f};

  stick_to_position_integrator_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  stick_position_checker position_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall patterns of its own, every eighth stretch a long hold-off
  initial begin : receiver
    int kind;
    int len;
    int stretch;
    stretch = 0;
    while (rst) @(posedge clk);
    forever begin
      stretch++;
      if (stretch % 8 == 3) begin
        m_tready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        kind = $urandom_range(0, 3);
        len  = $urandom_range(10, 80);
        repeat (len) begin
          case (kind)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_frame(logic [7:0] x, logic [7:0] y, logic [3:0] dir);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, dir, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frames_sent++;
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop offering frames until every position beat is back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(stia_pkg::reg_index_t idx, logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(stia_pkg::mode_t m, logic [1:0] sens, logic psel);
    drain();
    put_reg(stia_pkg::REG_VARIANT, {1'b0, m});
    put_reg(stia_pkg::REG_SENSITIVITY, sens);
    put_reg(stia_pkg::REG_PLAYER_SELECT, {1'b0, psel});
    cfg_valid <= 1'b0;
    config_phases++;
  endtask

  function automatic logic [7:0] pick_reading();
    logic [7:0] mark;
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: begin
        mark = zone_marks[$urandom_range(0, 18)];
        return mark + 8'($urandom_range(0, 2)) - 8'd1;
      end
      2: return 8'($urandom_range(8'h60, 8'ha0));
      default: return $urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                           : 8'($urandom_range(8'hf7, 8'hff));
    endcase
  endfunction

  initial begin : stimulus
    stia_pkg::mode_t m;
    logic [1:0] sens;
    logic       psel;
    int         phase;
    int         count;
    int         sent;
    int         burst;
    int         gap;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, direction priority, zone edges
    set_config(stia_pkg::MODE_TRACKBALL, 2'd0, 1'b0);
    send_frame(8'h00, 8'hff, 4'h0);
    send_frame(8'hff, 8'h00, 4'hf);
    send_frame(8'h80, 8'h80, 4'h3);
    send_frame(8'h80, 8'h80, 4'hc);
    send_frame(8'h80, 8'h80, 4'h1);
    send_frame(8'h80, 8'h80, 4'h2);
    send_frame(8'h80, 8'h80, 4'h4);
    send_frame(8'h80, 8'h80, 4'h8);
    send_frame(8'h1f, 8'h5f, 4'h0);
    send_frame(8'h20, 8'h60, 4'h0);
    send_frame(8'he0, 8'ha0, 4'h0);
    send_frame(8'hdf, 8'h9f, 4'h0);
    send_frame(8'h81, 8'h7f, 4'h5);
    // no table: direction steps only
    set_config(stia_pkg::MODE_TRACKBALL, stia_pkg::SensNone, 1'b0);
    send_frame(8'h00, 8'hff, 4'ha);
    send_frame(8'hff, 8'h00, 4'h5);
    set_config(stia_pkg::MODE_PADDLE, 2'd0, 1'b0);
    send_frame(8'hff, 8'h00, 4'h0);
    send_frame(8'h00, 8'hff, 4'h0);
    send_frame(8'h80, 8'h12, 4'hf);
    set_config(stia_pkg::MODE_PADDLE, 2'd2, 1'b1);
    send_frame(8'hf8, 8'h00, 4'h0);
    send_frame(8'h07, 8'hff, 4'hf);
    send_frame(8'h98, 8'h55, 4'h3);
    send_frame(8'h67, 8'haa, 4'hc);
    set_config(stia_pkg::MODE_PADDLE, stia_pkg::SensNone, 1'b0);
    send_frame(8'h00, 8'h00, 4'h0);

    // random phases: every mode, sensitivity and player first, then random settings
    phase = 0;
    while (frames_sent < FrameTarget) begin
      if (phase < 4) begin
        m    = stia_pkg::MODE_TRACKBALL;
        sens = 2'(phase);
        psel = 1'($urandom_range(0, 1));
      end else if (phase < 12) begin
        m    = stia_pkg::MODE_PADDLE;
        sens = 2'((phase - 4) % 4);
        psel = ((phase - 4) / 4) != 0;
      end else begin
        m    = stia_pkg::mode_t'($urandom_range(0, 1));
        sens = 2'($urandom_range(0, 3));
        psel = 1'($urandom_range(0, 1));
      end
      set_config(m, sens, psel);
      count = $urandom_range(40, 120);
      sent  = 0;
      while (sent < count) begin
        burst = $urandom_range(1, 40);
        repeat (burst) begin
          send_frame(pick_reading(), pick_reading(), 4'($urandom_range(0, 15)));
          sent++;
        end
        if ($urandom_range(0, 15) == 0) begin
          drain();
        end else begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          pause(gap);
        end
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("run covered %0d frames over %0d config settings", frames_sent, config_phases);
    $display("both modes, all sensitivity codes, both players, zone edges and clamping");
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/stia_pkg.sv
rtl/stia_zone.sv
rtl/stia_update.sv
rtl/stick_to_position_integrator_core.sv
test/stick_position_checker.sv
test/stick_to_position_integrator_core_tb.sv
